// ===== sv/lbm_d2q5_reaction_collision_unit_macros.svh =====
// ----------------------------------------------------------------------------
// lbm_d2q5_reaction_collision_unit_macros.svh
// Assertion macros shared by the checker of the reaction collision unit.
// ----------------------------------------------------------------------------
`ifndef LBM_D2Q5_REACTION_COLLISION_UNIT_MACROS_SVH
`define LBM_D2Q5_REACTION_COLLISION_UNIT_MACROS_SVH

// property must hold on every clock while out of reset
`define LRC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true while out of reset
`define LRC_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== sv/lrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types, constants and saturation helper of the reaction collision unit.
// ----------------------------------------------------------------------------
package lrc_pkg;

	localparam int Q_W       = 32;
	localparam int W_W       = 23;
	localparam int DIRS      = 5;
	localparam int OM1_W     = 27;
	localparam int EQ_W      = 35;
	localparam int DEN_W     = 49;
	localparam int LATENCY   = 76;

	localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic [W_W-1:0] W_THIRD = 23'd5592405;
	localparam logic [W_W-1:0] W_SIXTH = 23'd2796203;

	typedef enum logic [2:0] {
		REG_OMEGA_N   = 3'd0,
		REG_OMEGA_B   = 3'd1,
		REG_THRESHOLD = 3'd2,
		REG_INV_A1    = 3'd3,
		REG_INV_A2    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic                    sat;
		logic signed [Q_W-1:0]   val;
	} sat_t;

	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		r.sat = 1'b0;
		r.val = v[Q_W-1:0];
		if (v > 64'sd2147483647) begin
			r.sat = 1'b1;
			r.val = Q_MAX;
		end else if (v < -64'sd2147483648) begin
			r.sat = 1'b1;
			r.val = Q_MIN;
		end
		return r;
	endfunction

endpackage

// ===== sv/lrc_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_divider
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero, with a 32 bit saturated quotient and a pass-through flag.
// ----------------------------------------------------------------------------
module lrc_divider import lrc_pkg::*; #(
	parameter int NUM_W = 50,
	parameter int DEN_W = 49
) (
	input  logic                     clk,
	input  logic                     flag_in,
	input  logic signed [NUM_W-1:0]  num,
	input  logic signed [DEN_W-1:0]  den,
	output logic signed [Q_W-1:0]    quot,
	output logic                     flag_out
);

	localparam int RW = DEN_W + 1;

	typedef struct packed {
		logic [RW-1:0]    rem;
		logic [Q_W-1:0]   lo;
		logic [Q_W-1:0]   qb;
		logic [DEN_W-1:0] b;
		logic             neg;
		logic             zero;
		logic             ovf;
		logic             flag;
	} div_stage_t;

	div_stage_t stg_s [0:Q_W];
	div_stage_t prep;
	logic [NUM_W-1:0] a_mag;
	logic [DEN_W-1:0] b_mag;

	always_comb begin
		a_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		b_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
		prep.rem  = RW'(a_mag[NUM_W-1:Q_W]);
		prep.lo   = a_mag[Q_W-1:0];
		prep.qb   = '0;
		prep.b    = b_mag;
		prep.neg  = num[NUM_W-1] ^ den[DEN_W-1];
		prep.zero = (den == '0);
		prep.ovf  = RW'(a_mag[NUM_W-1:Q_W]) >= {1'b0, b_mag};
		prep.flag = flag_in;
	end

	always_ff @(posedge clk) begin
		stg_s[0] <= prep;
	end

	for (genvar i = 0; i < Q_W; i++) begin : g_step
		logic [RW-1:0] trial;
		logic          take;
		div_stage_t    nxt;
		always_comb begin
			trial = {stg_s[i].rem[RW-2:0], stg_s[i].lo[Q_W-1]};
			take  = trial >= {1'b0, stg_s[i].b};
			nxt   = stg_s[i];
			nxt.rem = take ? trial - {1'b0, stg_s[i].b} : trial;
			nxt.lo  = {stg_s[i].lo[Q_W-2:0], 1'b0};
			nxt.qb  = {stg_s[i].qb[Q_W-2:0], take};
		end
		always_ff @(posedge clk) begin
			stg_s[i+1] <= nxt;
		end
	end

	div_stage_t fin;
	logic signed [Q_W-1:0] q_nxt;
	logic                  f_nxt;

	always_comb begin
		fin   = stg_s[Q_W];
		q_nxt = $signed(fin.qb);
		f_nxt = fin.flag;
		if (fin.zero) begin
			q_nxt = Q_MAX;
			f_nxt = 1'b1;
		end else if (fin.ovf) begin
			q_nxt = fin.neg ? Q_MIN : Q_MAX;
			f_nxt = 1'b1;
		end else if (fin.neg) begin
			if (fin.qb > 32'h8000_0000) begin
				q_nxt = Q_MIN;
				f_nxt = 1'b1;
			end else begin
				q_nxt = $signed(-fin.qb);
			end
		end else if (fin.qb[Q_W-1]) begin
			q_nxt = Q_MAX;
			f_nxt = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		quot     <= q_nxt;
		flag_out <= f_nxt;
	end

endmodule

// ===== sv/lrc_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_lane
// One direction of BGK relaxation for nutrient and bacteria: products in the
// first stage, sum and saturation in the second.
// ----------------------------------------------------------------------------
module lrc_lane import lrc_pkg::*; (
	input  logic                     clk,
	input  logic [W_W-1:0]           w,
	input  logic signed [OM1_W-1:0]  om1_n,
	input  logic signed [OM1_W-1:0]  om1_b,
	input  logic signed [EQ_W-1:0]   eq_n,
	input  logic signed [EQ_W-1:0]   eq_b,
	input  logic signed [Q_W-1:0]    f_n,
	input  logic signed [Q_W-1:0]    f_b,
	input  logic signed [Q_W-1:0]    react_n,
	input  logic signed [Q_W-1:0]    react_b,
	output logic signed [Q_W-1:0]    post_n,
	output logic signed [Q_W-1:0]    post_b,
	output logic                     sat
);

	logic signed [W_W:0]  ws;
	logic signed [58:0]   pa_n_s1, pa_b_s1, pe_n_s1, pe_b_s1;
	logic signed [55:0]   pr_n_s1, pr_b_s1;
	logic signed [36:0]   sum_n, sum_b;
	sat_t                 rn, rb;

	assign ws = $signed({1'b0, w});

	always_ff @(posedge clk) begin
		pa_n_s1 <= 59'(om1_n) * 59'(f_n);
		pa_b_s1 <= 59'(om1_b) * 59'(f_b);
		pe_n_s1 <= 59'(eq_n) * 59'(ws);
		pe_b_s1 <= 59'(eq_b) * 59'(ws);
		pr_n_s1 <= 56'(ws) * 56'(react_n);
		pr_b_s1 <= 56'(ws) * 56'(react_b);
	end

	always_comb begin
		sum_n = 37'(pa_n_s1 >>> 24) + 37'(pe_n_s1 >>> 24) + 37'(pr_n_s1 >>> 24);
		sum_b = 37'(pa_b_s1 >>> 24) + 37'(pe_b_s1 >>> 24) + 37'(pr_b_s1 >>> 24);
		rn = sat32(64'(sum_n));
		rb = sat32(64'(sum_b));
	end

	always_ff @(posedge clk) begin
		post_n <= rn.val;
		post_b <= rb.val;
		sat    <= rn.sat | rb.sat;
	end

endmodule

// ===== sv/lbm_d2q5_reaction_collision_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbm_d2q5_reaction_collision_unit
// D2Q5 lattice-Boltzmann reaction collision for one cell per beat: densities,
// death rate through two pipelined dividers, reaction, dead density update
// and BGK relaxation in five direction lanes merged into one result.
//
//   channel   signals                          direction  flow control
//   cell in   start, busy, nutr_f*, bact_f*,   in         start & !busy
//             dead_in
//   result    done, nutr_post*, bact_post*,    out        done, no stall
//             dead_out, saturated
//   config    cfg_valid, cfg_ready,            in         valid & ready
//             cfg_index, cfg_data
//
// A new cell is taken every cycle; busy stays low.
// Each result follows its cell through the two bit-per-stage dividers
// of the death rate.
// Reset clears the valid chain and loads the default configuration.
// The result side cannot stall; done lasts one cycle per beat.
// ----------------------------------------------------------------------------
module lbm_d2q5_reaction_collision_unit import lrc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic signed [31:0]    nutr_f0,
	input  logic signed [31:0]    nutr_f1,
	input  logic signed [31:0]    nutr_f2,
	input  logic signed [31:0]    nutr_f3,
	input  logic signed [31:0]    nutr_f4,
	input  logic signed [31:0]    bact_f0,
	input  logic signed [31:0]    bact_f1,
	input  logic signed [31:0]    bact_f2,
	input  logic signed [31:0]    bact_f3,
	input  logic signed [31:0]    bact_f4,
	input  logic signed [31:0]    dead_in,
	output logic signed [31:0]    nutr_post0,
	output logic signed [31:0]    nutr_post1,
	output logic signed [31:0]    nutr_post2,
	output logic signed [31:0]    nutr_post3,
	output logic signed [31:0]    nutr_post4,
	output logic signed [31:0]    bact_post0,
	output logic signed [31:0]    bact_post1,
	output logic signed [31:0]    bact_post2,
	output logic signed [31:0]    bact_post3,
	output logic signed [31:0]    bact_post4,
	output logic signed [31:0]    dead_out,
	output logic                  saturated
);

	localparam int S_SIDE0 = 3;
	localparam int S_DIV1  = 36;
	localparam int S_DIV2  = 70;
	localparam int S_LAST  = 73;

	typedef struct packed {
		logic [DIRS-1:0][Q_W-1:0] fn;
		logic [DIRS-1:0][Q_W-1:0] fb;
		logic signed [Q_W-1:0]    dead;
		logic signed [Q_W-1:0]    rb;
		logic signed [EQ_W-1:0]   eq_n;
		logic signed [EQ_W-1:0]   eq_b;
		logic signed [Q_W-1:0]    coeff;
		logic signed [DEN_W-1:0]  d2;
		logic                     flag;
	} side_t;

	// configuration
	logic [25:0] omega_n_q, omega_b_q;
	logic [30:0] thr_q;
	logic [15:0] ia1_q, ia2_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			omega_n_q <= 26'd6710886;
			omega_b_q <= 26'd22672050;
			thr_q     <= 31'd0;
			ia1_q     <= 16'd2400;
			ia2_q     <= 16'd120;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OMEGA_N:   omega_n_q <= cfg_data[25:0];
				REG_OMEGA_B:   omega_b_q <= cfg_data[25:0];
				REG_THRESHOLD: thr_q     <= cfg_data[30:0];
				REG_INV_A1:    ia1_q     <= cfg_data[15:0];
				REG_INV_A2:    ia2_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// valid chain
	logic [LATENCY:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LATENCY-1:1], start & ~busy};
		end
	end

	assign done = vld_s[LATENCY];

	// stage 1: densities
	logic signed [34:0] sum_n, sum_b;
	sat_t sn_sat, sb_sat;
	logic [DIRS-1:0][Q_W-1:0] fn_s1, fb_s1;
	logic signed [Q_W-1:0] rn_s1, rb_s1, dead_s1;
	logic flag_s1;

	always_comb begin
		sum_n = 35'(nutr_f0) + 35'(nutr_f1) + 35'(nutr_f2) + 35'(nutr_f3) + 35'(nutr_f4);
		sum_b = 35'(bact_f0) + 35'(bact_f1) + 35'(bact_f2) + 35'(bact_f3) + 35'(bact_f4);
		sn_sat = sat32(64'(sum_n));
		sb_sat = sat32(64'(sum_b));
	end

	always_ff @(posedge clk) begin
		fn_s1   <= {nutr_f4, nutr_f3, nutr_f2, nutr_f1, nutr_f0};
		fb_s1   <= {bact_f4, bact_f3, bact_f2, bact_f1, bact_f0};
		dead_s1 <= dead_in;
		rn_s1   <= sn_sat.val;
		rb_s1   <= sb_sat.val;
		flag_s1 <= sn_sat.sat | sb_sat.sat;
	end

	// stage 2: denominators and density products
	logic [DIRS-1:0][Q_W-1:0] fn_s2, fb_s2;
	logic signed [Q_W-1:0]   rb_s2, dead_s2;
	logic signed [DEN_W-1:0] d1_s2, d2_s2;
	logic signed [63:0]      prr_s2;
	logic signed [58:0]      pen_s2, peb_s2;
	logic                    ge_s2, flag_s2;

	always_ff @(posedge clk) begin
		fn_s2   <= fn_s1;
		fb_s2   <= fb_s1;
		rb_s2   <= rb_s1;
		dead_s2 <= dead_s1;
		flag_s2 <= flag_s1;
		d1_s2   <= 49'sd16777216 + 49'(rb_s1) * 49'($signed({1'b0, ia1_q}));
		d2_s2   <= 49'sd16777216 + 49'(rn_s1) * 49'($signed({1'b0, ia2_q}));
		prr_s2  <= 64'(rb_s1) * 64'(rn_s1);
		pen_s2  <= 59'($signed({1'b0, omega_n_q})) * 59'(rn_s1);
		peb_s2  <= 59'($signed({1'b0, omega_b_q})) * 59'(rb_s1);
		ge_s2   <= $signed({rb_s1[31], rb_s1}) >= $signed({2'b00, thr_q});
	end

	// side line carried past the dividers
	side_t side_s [S_SIDE0:S_LAST];
	side_t side_in;
	sat_t  coeff_sat;

	always_comb begin
		coeff_sat     = sat32(prr_s2 >>> 24);
		side_in.fn    = fn_s2;
		side_in.fb    = fb_s2;
		side_in.dead  = dead_s2;
		side_in.rb    = rb_s2;
		side_in.eq_n  = EQ_W'(pen_s2 >>> 24);
		side_in.eq_b  = EQ_W'(peb_s2 >>> 24);
		side_in.coeff = ge_s2 ? coeff_sat.val : '0;
		side_in.d2    = d2_s2;
		side_in.flag  = flag_s2 | (ge_s2 & coeff_sat.sat);
	end

	always_ff @(posedge clk) begin
		side_s[S_SIDE0] <= side_in;
	end

	for (genvar k = S_SIDE0 + 1; k <= S_LAST; k++) begin : g_side
		always_ff @(posedge clk) begin
			side_s[k] <= side_s[k-1];
		end
	end

	// death rate: q = 2^48 / d1, mu = q * 2^24 / d2
	logic signed [Q_W-1:0] q_s36, mu_s70;
	logic flag_q_s36, flag_mu_s70;

	lrc_divider #(.NUM_W(50), .DEN_W(DEN_W)) u_div_q (
		.clk      (clk),
		.flag_in  (1'b0),
		.num      (50'sh1_0000_0000_0000),
		.den      (d1_s2),
		.quot     (q_s36),
		.flag_out (flag_q_s36)
	);

	lrc_divider #(.NUM_W(56), .DEN_W(DEN_W)) u_div_mu (
		.clk      (clk),
		.flag_in  (flag_q_s36),
		.num      ($signed({q_s36, 24'd0})),
		.den      (side_s[S_DIV1].d2),
		.quot     (mu_s70),
		.flag_out (flag_mu_s70)
	);

	// stages 71..73: death, reaction, dead density
	logic signed [63:0]    pmd_s71;
	logic                  flag_s71;
	logic signed [Q_W-1:0] death_s72;
	logic                  flag_s72;
	sat_t                  death_sat, rn_r, rb_r, dead_r;
	logic signed [Q_W-1:0] react_n_s73, react_b_s73, dead_s73;
	logic                  flag_s73;

	always_ff @(posedge clk) begin
		pmd_s71  <= 64'(mu_s70) * 64'(side_s[S_DIV2].rb);
		flag_s71 <= flag_mu_s70;
	end

	assign death_sat = sat32(pmd_s71 >>> 24);

	always_ff @(posedge clk) begin
		death_s72 <= death_sat.val;
		flag_s72  <= flag_s71 | death_sat.sat;
	end

	always_comb begin
		rn_r   = sat32(-64'(side_s[S_LAST-1].coeff));
		rb_r   = sat32(64'(side_s[S_LAST-1].coeff) - 64'(death_s72));
		dead_r = sat32(64'(side_s[S_LAST-1].dead) + 64'(death_s72));
	end

	always_ff @(posedge clk) begin
		react_n_s73 <= rn_r.val;
		react_b_s73 <= rb_r.val;
		dead_s73    <= dead_r.val;
		flag_s73    <= side_s[S_LAST-1].flag | flag_s72 | rn_r.sat | rb_r.sat | dead_r.sat;
	end

	// lanes
	logic signed [OM1_W-1:0] om1_n, om1_b;
	logic signed [Q_W-1:0]   post_n [DIRS];
	logic signed [Q_W-1:0]   post_b [DIRS];
	logic [DIRS-1:0]         lane_sat;

	assign om1_n = 27'sd16777216 - $signed({1'b0, omega_n_q});
	assign om1_b = 27'sd16777216 - $signed({1'b0, omega_b_q});

	for (genvar k = 0; k < DIRS; k++) begin : g_lane
		lrc_lane u_lane (
			.clk     (clk),
			.w       ((k == 0) ? W_THIRD : W_SIXTH),
			.om1_n   (om1_n),
			.om1_b   (om1_b),
			.eq_n    (side_s[S_LAST].eq_n),
			.eq_b    (side_s[S_LAST].eq_b),
			.f_n     ($signed(side_s[S_LAST].fn[k])),
			.f_b     ($signed(side_s[S_LAST].fb[k])),
			.react_n (react_n_s73),
			.react_b (react_b_s73),
			.post_n  (post_n[k]),
			.post_b  (post_b[k]),
			.sat     (lane_sat[k])
		);
	end

	logic signed [Q_W-1:0] dead_s74, dead_s75;
	logic                  flag_s74, flag_s75;

	always_ff @(posedge clk) begin
		dead_s74 <= dead_s73;
		dead_s75 <= dead_s74;
		flag_s74 <= flag_s73;
		flag_s75 <= flag_s74;
	end

	// merge
	logic signed [Q_W-1:0] nutr_s76 [DIRS];
	logic signed [Q_W-1:0] bact_s76 [DIRS];
	logic signed [Q_W-1:0] dead_s76;
	logic                  sat_s76;

	always_ff @(posedge clk) begin
		nutr_s76 <= post_n;
		bact_s76 <= post_b;
		dead_s76 <= dead_s75;
		sat_s76  <= flag_s75 | (|lane_sat);
	end

	assign nutr_post0 = nutr_s76[0];
	assign nutr_post1 = nutr_s76[1];
	assign nutr_post2 = nutr_s76[2];
	assign nutr_post3 = nutr_s76[3];
	assign nutr_post4 = nutr_s76[4];
	assign bact_post0 = bact_s76[0];
	assign bact_post1 = bact_s76[1];
	assign bact_post2 = bact_s76[2];
	assign bact_post3 = bact_s76[3];
	assign bact_post4 = bact_s76[4];
	assign dead_out   = dead_s76;
	assign saturated  = sat_s76;

endmodule

// ===== sv/lrc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_checker
// Port-level checks of the reaction collision unit: fixed result latency,
// no result without a cell, configuration never stalled.
// ----------------------------------------------------------------------------
`include "lbm_d2q5_reaction_collision_unit_macros.svh"

module lrc_checker import lrc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_valid,
	input logic cfg_ready
);

	`LRC_ASSERT(a_latency, clk, arst_n, (start && !busy) |-> ##LATENCY done, "result beat missing")
	`LRC_ASSERT(a_no_orphan, clk, arst_n, done |-> $past(start && !busy, LATENCY), "result without cell")
	`LRC_NEVER(a_cfg_stall, clk, arst_n, cfg_valid && !cfg_ready, "config beat stalled")

endmodule

bind lbm_d2q5_reaction_collision_unit lrc_checker u_lrc_checker (.*);
